### design/running_mean_stdev_welford_macros.svh
// Assertion macros for the running mean and deviation block.
// Expects clk and rst in the scope of each use.
`ifndef RUNNING_MEAN_STDEV_WELFORD_MACROS_SVH
`define RUNNING_MEAN_STDEV_WELFORD_MACROS_SVH

// ante implies cons in the same cycle
`define RMSW_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the following cycle
`define RMSW_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rmsw_pkg.sv
// Shared widths, limits and sequencer states of the running mean and deviation block.
// No dependencies.
package rmsw_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CNT_W     = 16;
  localparam int MEAN_W    = 48;
  localparam int MEAN_FRAC = 24;
  localparam int M2_W      = 64;
  localparam int OUT_W     = 32;
  localparam int MAG_W     = 40;
  localparam int HALF_W    = MAG_W / 2;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int ROOT_W    = M2_W / 2;
  localparam int REM_W     = ROOT_W + 1;
  localparam int CS_W      = REM_W + 2;
  localparam int STEP_W    = 6;
  localparam int OUT_SHIFT = MEAN_FRAC - 16;

  localparam logic [CNT_W-1:0]  MAX_SAMPLES    = 16'd65535;
  localparam logic [STEP_W-1:0] MEAN_DIV_LAST  = STEP_W'(MAG_W - 1);
  localparam logic [STEP_W-1:0] VAR_DIV_LAST   = STEP_W'(M2_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST      = STEP_W'(ROOT_W - 1);
  localparam logic [STEP_W-1:0] MUL_LAST       = STEP_W'(4);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVM,
    ST_UPD,
    ST_DLT2,
    ST_MUL,
    ST_ACC,
    ST_VSET,
    ST_DIVV,
    ST_SSET,
    ST_SQRT,
    ST_FIN
  } state_t;

endpackage

### design/rmsw_sample_if.sv
// Sample request channel: valid/ready with one signed sample and a restart flag.
// Depends on rmsw_pkg.
interface rmsw_sample_if import rmsw_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

### design/rmsw_stats_if.sv
// Statistics result channel: valid/ready with count, mean, deviation and flags.
// Depends on rmsw_pkg.
interface rmsw_stats_if import rmsw_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CNT_W-1:0]        sample_total;
  logic signed [OUT_W-1:0] mean_out;
  logic [OUT_W-1:0]        stdev_out;
  logic                    valid_res;
  logic                    saturated;

  modport source (output valid, output sample_total, output mean_out, output stdev_out,
                  output valid_res, output saturated, input ready);
  modport sink (input valid, input sample_total, input mean_out, input stdev_out,
                input valid_res, input saturated, output ready);
endinterface

### design/running_mean_stdev_welford.sv
// Running mean and sample standard deviation by Welford's rule, one shared
// compare-subtract unit for both divisions and the square root.
// Depends on rmsw_pkg, rmsw_sample_if, rmsw_stats_if and the macros header.
//
//   channel  | dir | payload
//   ---------+-----+----------------------------------------------------------
//   samples  | in  | sample (s16), restart (1)
//   stats    | out | sample_total (u16), mean_out (s32 Q16.16),
//            |     | stdev_out (u32 Q16.16), valid_res (1), saturated (1)
//
// An accepted sample runs the mean division, the 20x20 partial products, the
// variance division and the root; the divisions and the root all go through the
// one compare-subtract unit. A sample dropped at the count limit skips the mean
// update and runs only the variance division and root; one that leaves fewer
// than two samples skips the variance and root. Ready is high only when the
// sequencer is idle; the result register lets the next sample in while the last
// result waits, and a full result register stalls the sequencer at its final
// step. Reset is synchronous and clears the aggregate.
`include "running_mean_stdev_welford_macros.svh"

module running_mean_stdev_welford import rmsw_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  rmsw_sample_if.sink   samples,
  rmsw_stats_if.source  stats
);

  state_t state, state_next;

  logic [CNT_W-1:0]          sample_count;
  logic signed [MEAN_W-1:0]  running_mean;
  logic [M2_W-1:0]           sum_sq_dev;

  logic signed [SAMPLE_W-1:0] samp;
  logic                       drop;
  logic [MAG_W-1:0]           dmag;
  logic                       dneg;
  logic [MAG_W-1:0]           d2mag;
  logic [M2_W-1:0]            wq;
  logic [REM_W-1:0]           rem;
  logic [ROOT_W-1:0]          root;
  logic [CNT_W-1:0]           divr;
  logic [STEP_W-1:0]          step;
  logic [MAG_W-1:0]           pp;
  logic [PROD_W-1:0]          acc;

  logic                    o_valid;
  logic [CNT_W-1:0]        o_total;
  logic signed [OUT_W-1:0] o_mean;
  logic [OUT_W-1:0]        o_stdev;
  logic                    o_vres;
  logic                    o_sat;

  logic                   in_req;
  logic                   in_drop;
  logic                   out_free;
  logic                   fin_load;
  logic                   step_last;
  logic                   enough;

  logic signed [MEAN_W-1:0] target;
  logic [MEAN_W-1:0]        diff_full;
  logic [MEAN_W-1:0]        diff_abs;
  logic [MEAN_W-1:0]        quot;

  logic [CS_W-1:0] cs_a;
  logic [CS_W-1:0] cs_b;
  logic [CS_W-1:0] cs_diff;
  logic            cs_ge;

  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [MAG_W-1:0]  mul_p;
  logic [PROD_W-1:0] pp_wide;
  logic [PROD_W-1:0] pp_shifted;

  logic [M2_W:0]        m2_sum;
  logic [MEAN_W-1:0]    mean_rnd;

  assign in_req    = samples.valid && samples.ready;
  assign in_drop   = !samples.restart && (sample_count >= MAX_SAMPLES);
  assign out_free  = !o_valid || stats.ready;
  assign step_last = (step == '0);
  assign enough    = (sample_count >= CNT_W'(2));

  assign target = {{(MEAN_W-SAMPLE_W-MEAN_FRAC){samp[SAMPLE_W-1]}}, samp, {MEAN_FRAC{1'b0}}};
  assign diff_full = target - running_mean;
  assign diff_abs  = diff_full[MEAN_W-1] ? (MEAN_W'(0) - diff_full) : diff_full;
  assign quot      = {{(MEAN_W-MAG_W){1'b0}}, wq[MAG_W-1:0]};

  // shared compare-subtract unit
  always_comb begin
    if (state == ST_SQRT) begin
      cs_a = {rem, wq[M2_W-1 -: 2]};
      cs_b = {{(CS_W-ROOT_W-2){1'b0}}, root, 2'b01};
    end else begin
      cs_a = {{(CS_W-CNT_W-1){1'b0}}, rem[CNT_W-1:0], wq[M2_W-1]};
      cs_b = {{(CS_W-CNT_W){1'b0}}, divr};
    end
  end
  assign cs_ge   = (cs_a >= cs_b);
  assign cs_diff = cs_a - cs_b;

  assign mul_a = step[0] ? dmag[MAG_W-1:HALF_W] : dmag[HALF_W-1:0];
  assign mul_b = step[1] ? d2mag[MAG_W-1:HALF_W] : d2mag[HALF_W-1:0];
  assign mul_p = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
  assign pp_wide = {{(PROD_W-MAG_W){1'b0}}, pp};

  always_comb begin
    unique case (step)
      STEP_W'(1):  pp_shifted = pp_wide;
      MUL_LAST:    pp_shifted = pp_wide << (2 * HALF_W);
      default:     pp_shifted = pp_wide << HALF_W;
    endcase
  end

  assign m2_sum   = {1'b0, sum_sq_dev} + {{(M2_W+1-(PROD_W-32)){1'b0}}, acc[PROD_W-1:32]};
  assign mean_rnd = running_mean + MEAN_W'(1 << (OUT_SHIFT - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (samples.valid) state_next = in_drop ? ST_VSET : ST_LOAD;
      ST_LOAD: state_next = ST_DIVM;
      ST_DIVM: if (step_last) state_next = ST_UPD;
      ST_UPD:  state_next = ST_DLT2;
      ST_DLT2: state_next = ST_MUL;
      ST_MUL:  if (step == MUL_LAST) state_next = ST_ACC;
      ST_ACC:  state_next = ST_VSET;
      ST_VSET: state_next = enough ? ST_DIVV : ST_FIN;
      ST_DIVV: if (step_last) state_next = ST_SSET;
      ST_SSET: state_next = ST_SQRT;
      ST_SQRT: if (step_last) state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    samples.ready = (state == ST_IDLE);
    fin_load      = (state == ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      running_mean <= '0;
      sum_sq_dev   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_req) begin
            samp <= samples.sample;
            drop <= in_drop;
            if (samples.restart) begin
              sample_count <= '0;
              running_mean <= '0;
              sum_sq_dev   <= '0;
            end
          end
        end
        ST_LOAD: begin
          sample_count <= sample_count + CNT_W'(1);
          divr         <= sample_count + CNT_W'(1);
          dmag         <= diff_abs[MAG_W-1:0];
          dneg         <= diff_full[MEAN_W-1];
          wq           <= {diff_abs[MAG_W-1:0], {(M2_W-MAG_W){1'b0}}};
          rem          <= '0;
          step         <= MEAN_DIV_LAST;
        end
        ST_DIVM, ST_DIVV: begin
          wq   <= {wq[M2_W-2:0], cs_ge};
          rem  <= cs_ge ? cs_diff[REM_W-1:0] : cs_a[REM_W-1:0];
          step <= step - STEP_W'(1);
        end
        ST_UPD: begin
          running_mean <= dneg ? (running_mean - quot) : (running_mean + quot);
        end
        ST_DLT2: begin
          d2mag <= diff_abs[MAG_W-1:0];
          acc   <= '0;
          step  <= '0;
        end
        ST_MUL: begin
          if (step != MUL_LAST) pp <= mul_p;
          if (step != '0) acc <= acc + pp_shifted;
          step <= step + STEP_W'(1);
        end
        ST_ACC: begin
          sum_sq_dev <= m2_sum[M2_W] ? {M2_W{1'b1}} : m2_sum[M2_W-1:0];
        end
        ST_VSET: begin
          wq   <= sum_sq_dev;
          rem  <= '0;
          divr <= sample_count - CNT_W'(1);
          step <= VAR_DIV_LAST;
        end
        ST_SSET: begin
          wq   <= (|wq[M2_W-1:M2_W-16]) ? {M2_W{1'b1}} : {wq[M2_W-17:0], 16'b0};
          rem  <= '0;
          root <= '0;
          step <= SQRT_LAST;
        end
        ST_SQRT: begin
          wq   <= {wq[M2_W-3:0], 2'b00};
          rem  <= cs_ge ? cs_diff[REM_W-1:0] : cs_a[REM_W-1:0];
          root <= {root[ROOT_W-2:0], cs_ge};
          step <= step - STEP_W'(1);
        end
        ST_FIN: begin
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (fin_load) begin
      o_valid <= 1'b1;
    end else if (stats.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      o_total <= sample_count;
      o_vres  <= enough;
      o_sat   <= drop;
      o_mean  <= enough ? mean_rnd[OUT_W+OUT_SHIFT-1:OUT_SHIFT] : '0;
      o_stdev <= enough ? root : '0;
    end
  end

  assign stats.valid        = o_valid;
  assign stats.sample_total = o_total;
  assign stats.mean_out     = o_mean;
  assign stats.stdev_out    = o_stdev;
  assign stats.valid_res    = o_vres;
  assign stats.saturated    = o_sat;

  `RMSW_IMPLIES(a_short_zero, o_valid && !o_vres, o_mean == '0 && o_stdev == '0, "short aggregate with nonzero stats")
  `RMSW_IMPLIES(a_drop_full, o_valid && o_sat, o_total == MAX_SAMPLES && o_vres, "drop below count limit")
  `RMSW_NEXT(a_busy_after_req, in_req, !samples.ready, "ready right after request")
  `RMSW_IMPLIES(a_rem_bound, state == ST_DIVM || state == ST_DIVV, rem < REM_W'(divr), "remainder not below divisor")

endmodule

### verif/tb_top.sv
// Self-checking bench for running_mean_stdev_welford: a directed table, then ~500 random
// samples with bursty requests and a stalling receiver, checked against a Welford predictor.
// Depends on running_mean_stdev_welford, rmsw_pkg, rmsw_sample_if and rmsw_stats_if.
`timescale 1ns / 1ps

module tb_top;
  import rmsw_pkg::*;

  localparam int  CLK_PERIOD  = 4;
  localparam int  RAND_ITEMS  = 500;
  localparam int  DRAIN_WAIT  = 200;
  localparam int  LONG_HOLD   = 1500;
  localparam int  CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [OUT_W-1:0] mean;
    logic [OUT_W-1:0] stdev;
    logic             valid_res;
    logic             saturated;
  } stats_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    bit                         restart;
    bit                         pinned;
    stats_t                     want;
  } vector_t;

  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

  localparam stats_t FRESH  = '{16'd1, 32'd0, 32'd0, 1'b0, 1'b0};
  localparam stats_t NO_PIN = '0;
  localparam int DIRECTED_N = 22;

  vector_t directed_tbl [DIRECTED_N] = '{
    '{16'sd0,      1'b0, 1'b1, FRESH},
    '{16'sd0,      1'b0, 1'b1, '{16'd2, 32'd0, 32'd0, 1'b1, 1'b0}},
    '{16'sd32767,  1'b1, 1'b1, FRESH},
    '{16'sd32767,  1'b0, 1'b1, '{16'd2, 32'h7FFF_0000, 32'd0, 1'b1, 1'b0}},
    '{16'sd32767,  1'b0, 1'b1, '{16'd3, 32'h7FFF_0000, 32'd0, 1'b1, 1'b0}},
    '{-16'sd32768, 1'b0, 1'b0, NO_PIN},
    '{-16'sd32768, 1'b1, 1'b1, FRESH},
    '{-16'sd32768, 1'b0, 1'b1, '{16'd2, 32'h8000_0000, 32'd0, 1'b1, 1'b0}},
    '{16'sd32767,  1'b0, 1'b0, NO_PIN},
    '{-16'sd32768, 1'b0, 1'b0, NO_PIN},
    '{16'sd32767,  1'b0, 1'b0, NO_PIN},
    '{16'sd1,      1'b1, 1'b1, FRESH},
    '{-16'sd1,     1'b0, 1'b0, NO_PIN},
    '{16'sd0,      1'b0, 1'b0, NO_PIN},
    '{16'sh5555,   1'b1, 1'b1, FRESH},
    '{16'shAAAA,   1'b0, 1'b0, NO_PIN},
    '{16'sh5555,   1'b0, 1'b0, NO_PIN},
    '{16'sd0,      1'b1, 1'b1, FRESH},
    '{16'sd0,      1'b1, 1'b1, FRESH},
    '{16'sd1,      1'b0, 1'b0, NO_PIN},
    '{16'sd1,      1'b0, 1'b0, NO_PIN},
    '{16'sd2,      1'b0, 1'b0, NO_PIN}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmsw_sample_if samples_if ();
  rmsw_stats_if  stats_if ();

  running_mean_stdev_welford uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .stats   (stats_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predicted aggregate
  logic [CNT_W-1:0] agg_cnt;
  longint           agg_mean;
  logic [M2_W-1:0]  agg_m2;

  stats_t expected_stats_q [$];
  stats_t oldest_stats;
  int     errors;
  int     requests_sent;
  int     restarts_sent;
  int     deepest_agg;
  int     results_seen;
  int     valid_results;
  int     cycle_cnt;

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [OUT_W-1:0] int_sqrt(input logic [63:0] x);
    logic [63:0] rem, root, b;
    rem  = x;
    root = '0;
    b    = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root[OUT_W-1:0];
  endfunction

  function automatic stats_t welford_step(input logic signed [SAMPLE_W-1:0] s,
                                          input bit restart);
    longint       target, delta, delta2, rounded;
    logic [63:0]  mag_d, mag_d2, quot, prod, variance, scaled;
    logic [127:0] wide;
    stats_t       r;
    r = '0;
    if (restart) begin
      agg_cnt  = '0;
      agg_mean = 0;
      agg_m2   = '0;
    end
    if (agg_cnt >= MAX_SAMPLES) begin
      r.saturated = 1'b1;
    end else begin
      target  = longint'(s) * (longint'(1) << MEAN_FRAC);
      agg_cnt = agg_cnt + 1'b1;
      delta   = target - agg_mean;
      mag_d   = magnitude(delta);
      quot    = mag_d / agg_cnt;
      if (delta < 0) agg_mean = agg_mean - longint'(quot);
      else agg_mean = agg_mean + longint'(quot);
      delta2 = target - agg_mean;
      mag_d2 = magnitude(delta2);
      wide   = 128'(mag_d) * 128'(mag_d2);
      prod   = wide[95:32];
      if (agg_m2 > ~64'd0 - prod) agg_m2 = '1;
      else agg_m2 = agg_m2 + prod;
    end
    r.total     = agg_cnt;
    r.valid_res = (agg_cnt >= 2);
    if (r.valid_res) begin
      rounded  = (agg_mean + (longint'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      r.mean   = rounded[OUT_W-1:0];
      variance = agg_m2 / (agg_cnt - 1);
      scaled   = (variance > (~64'd0 >> 16)) ? ~64'd0 : (variance << 16);
      r.stdev  = int_sqrt(scaled);
    end
    return r;
  endfunction

  task automatic send_request(input logic signed [SAMPLE_W-1:0] s, input bit restart,
                              input bit pinned, input stats_t want);
    stats_t predicted;
    samples_if.valid   <= 1'b1;
    samples_if.sample  <= s;
    samples_if.restart <= restart;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    predicted = welford_step(s, restart);
    expected_stats_q.push_back(pinned ? want : predicted);
    requests_sent++;
    if (restart) restarts_sent++;
    if (int'(agg_cnt) > deepest_agg) deepest_agg = agg_cnt;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && stats_if.valid && stats_if.ready) begin
      results_seen++;
      if (expected_stats_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual total %0d", $time,
                 stats_if.sample_total);
      end else begin
        oldest_stats = expected_stats_q.pop_front();
        check_field("sample_total", oldest_stats.total, stats_if.sample_total);
        check_field("mean_out", oldest_stats.mean, $unsigned(stats_if.mean_out));
        check_field("stdev_out", oldest_stats.stdev, stats_if.stdev_out);
        check_field("valid_res", oldest_stats.valid_res, stats_if.valid_res);
        check_field("saturated", oldest_stats.saturated, stats_if.saturated);
        if (oldest_stats.valid_res) valid_results++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_stats_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : receiver
    int          hold_left;
    int          seg_left;
    bit          held_once;
    ready_mode_t mode;
    hold_left = 0;
    seg_left  = 0;
    held_once = 1'b0;
    mode      = RDY_ALWAYS;
    stats_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      // hold off once mid-run so the block backs up into its input
      if (!held_once && results_seen >= 150) begin
        held_once = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        stats_if.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = ready_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(32, 400);
        end
        seg_left--;
        case (mode)
          RDY_ALWAYS: stats_if.ready <= 1'b1;
          RDY_COIN:   stats_if.ready <= 1'($urandom_range(0, 1));
          RDY_SPARSE: stats_if.ready <= ($urandom_range(0, 7) == 0);
          default:    stats_if.ready <= seg_left[2];
        endcase
      end
    end
  end

  initial begin : sender
    logic signed [SAMPLE_W-1:0] s;
    bit                         restart;
    int                         sensor_base, level, burst_left, gap;
    agg_cnt       = '0;
    agg_mean      = 0;
    agg_m2        = '0;
    errors        = 0;
    requests_sent = 0;
    restarts_sent = 0;
    deepest_agg   = 0;
    results_seen  = 0;
    valid_results = 0;
    cycle_cnt     = 0;
    sensor_base   = 0;
    burst_left    = 0;
    samples_if.valid   <= 1'b0;
    samples_if.sample  <= '0;
    samples_if.restart <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_tbl[i])
      send_request(directed_tbl[i].sample, directed_tbl[i].restart,
                   directed_tbl[i].pinned, directed_tbl[i].want);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      // frequent restarts early, then rare ones so an aggregate can grow deep
      restart = (i < RAND_ITEMS / 2) ? ($urandom_range(0, 15) == 0)
                                     : ($urandom_range(0, 199) == 0);
      if (restart) sensor_base = int'($urandom_range(0, 65535)) - 32768;
      case ($urandom_range(0, 9))
        0: s = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
        1, 2, 3: s = 16'($urandom());
        4, 5, 6, 7: begin
          level = sensor_base + int'($urandom_range(0, 128)) - 64;
          if (level > 32767) level = 32767;
          if (level < -32768) level = -32768;
          s = 16'(level);
        end
        default: s = 16'(int'($urandom_range(0, 64)) - 32);
      endcase
      send_request(s, restart, 1'b0, NO_PIN);

      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 170);
      end else begin
        burst_left--;
        gap = 0;
      end
      if (i == RAND_ITEMS / 2) begin
        samples_if.valid <= 1'b0;
        while (expected_stats_q.size() != 0) @(posedge clk);
      end else if (gap != 0) begin
        samples_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    samples_if.valid <= 1'b0;
    while (expected_stats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (expected_stats_q.size() != 0) errors++;
    $display("covered %0d requests (%0d restarts), aggregates up to %0d samples",
             requests_sent, restarts_sent, deepest_agg);
    $display("checked %0d results, %0d with valid statistics, %0d mismatches",
             results_seen, valid_results, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
